// ----- hw/rtl/hsfd_pkg.sv -----
`default_nettype none

package hsfd_pkg;

  // field widths
  localparam int DATA_W = 8;
  localparam int WORD_W = 16;
  localparam int TEMP_W = 9;
  localparam int HUM_W  = 7;

  // byte positions within a sensor frame
  typedef logic [2:0] pos_t;
  localparam pos_t POS_TEMP_HI  = 3'd0;
  localparam pos_t POS_TEMP_LO  = 3'd1;
  localparam pos_t POS_TEMP_CRC = 3'd2;
  localparam pos_t POS_HUM_HI   = 3'd3;
  localparam pos_t POS_HUM_LO   = 3'd4;
  localparam pos_t POS_HUM_CRC  = 3'd5;

  // crc-8, msb first, no final xor
  localparam logic [DATA_W-1:0] CRC_POLY = 8'h31;
  localparam logic [DATA_W-1:0] CRC_INIT = 8'hFF;

  // conversion constants: temp = (175*raw - 45*65536) / 65536, hum = 100*raw >> 16
  localparam int TPROD_W = 24;
  localparam int HPROD_W = 23;
  localparam int TNUM_W  = TPROD_W + 1;
  localparam logic [TPROD_W-1:0] TEMP_SCALE  = 24'd175;
  localparam logic [HPROD_W-1:0] HUM_SCALE   = 23'd100;
  localparam logic signed [TNUM_W-1:0] TEMP_OFFSET = 25'sd2949120;

  // queue between frame tracker and converter
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // one completed frame, raw words plus crc verdicts
  typedef struct packed {
    logic [WORD_W-1:0] temp_word;
    logic [WORD_W-1:0] hum_word;
    logic              temp_ok;
    logic              hum_ok;
  } frame_t;

  function automatic logic [DATA_W-1:0] crc8_update(input logic [DATA_W-1:0] crc,
                                                   input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] c;
    c = crc ^ data;
    for (int i = 0; i < DATA_W; i++) begin
      c = c[DATA_W-1] ? ({c[DATA_W-2:0], 1'b0} ^ CRC_POLY) : {c[DATA_W-2:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hsfd_if.sv -----
`default_nettype none

// byte channel into the decoder
interface hsfd_in_if;
  import hsfd_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              frame_start;
  modport source (output valid, data_byte, frame_start, input ready);
  modport sink (input valid, data_byte, frame_start, output ready);
endinterface

// converted reading out of the decoder
interface hsfd_out_if;
  import hsfd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_c;
  logic        [HUM_W-1:0]  humidity_pct;
  logic                     temp_crc_ok;
  logic                     hum_crc_ok;
  modport source (output valid, temperature_c, humidity_pct, temp_crc_ok, hum_crc_ok,
                  input ready);
  modport sink (input valid, temperature_c, humidity_pct, temp_crc_ok, hum_crc_ok,
                output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/humidity_sensor_frame_decoder_top.sv -----
`default_nettype none

// Sensor frame decoder: takes the six bytes of a temperature/humidity read
// frame (temp hi, temp lo, temp crc, hum hi, hum lo, hum crc), one byte per
// word on in_ch, and checks each 16-bit value against its CRC-8 (poly 0x31,
// init 0xff). After the sixth byte one word appears on out_ch with signed
// whole degrees Celsius, whole percent humidity and both crc verdicts.
// frame_start marks byte 0 and resyncs the frame at any point. A byte can be
// taken every cycle while in_ch.ready is high; the decoded word leaves through a
// two-entry queue, a multiply stage and the output register.
// in_ch.ready drops only when that queue is full because out_ch is stalled.
module humidity_sensor_frame_decoder_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hsfd_in_if.sink    in_ch,
  hsfd_out_if.source out_ch
);
  import hsfd_pkg::*;

  frame_t fr_wr_data, fr_rd_data;
  logic   fr_wr_valid, fr_wr_ready;
  logic   fr_rd_valid, fr_rd_ready;

  // byte tracking and crc check
  hsfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .frm_data  (fr_wr_data),
    .frm_valid (fr_wr_valid),
    .frm_ready (fr_wr_ready)
  );

  // frame queue
  hsfd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_data  (fr_wr_data),
    .wr_valid (fr_wr_valid),
    .wr_ready (fr_wr_ready),
    .rd_data  (fr_rd_data),
    .rd_valid (fr_rd_valid),
    .rd_ready (fr_rd_ready)
  );

  // unit conversion and output
  hsfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .frm_data  (fr_rd_data),
    .frm_valid (fr_rd_valid),
    .frm_ready (fr_rd_ready),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/hsfd_front.sv -----
`default_nettype none

module hsfd_front (
  input  wire logic      clk,
  input  wire logic      rst_n,
  hsfd_in_if.sink        in_ch,
  output hsfd_pkg::frame_t frm_data,
  output logic           frm_valid,
  input  wire logic      frm_ready
);
  import hsfd_pkg::*;

  pos_t              pos_r, pos_nxt, pos_eff;
  logic [DATA_W-1:0] crc_r, crc_nxt;
  logic [WORD_W-1:0] temp_word_r, temp_word_nxt;
  logic              temp_ok_r, temp_ok_nxt;
  logic [DATA_W-1:0] hum_hi_r, hum_hi_nxt;
  logic [DATA_W-1:0] hum_lo_r, hum_lo_nxt;
  logic              accept;

  assign in_ch.ready = frm_ready;
  assign accept      = in_ch.valid && frm_ready;

  // start flag or an unreachable position restarts the frame
  assign pos_eff = (in_ch.frame_start || pos_r > POS_HUM_CRC) ? POS_TEMP_HI : pos_r;

  // per-position update of crc and captured bytes
  always_comb begin
    crc_nxt       = crc_r;
    temp_word_nxt = temp_word_r;
    temp_ok_nxt   = temp_ok_r;
    hum_hi_nxt    = hum_hi_r;
    hum_lo_nxt    = hum_lo_r;
    unique case (pos_eff)
      POS_TEMP_HI: begin
        crc_nxt       = crc8_update(CRC_INIT, in_ch.data_byte);
        temp_word_nxt = {in_ch.data_byte, {DATA_W{1'b0}}};
      end
      POS_TEMP_LO: begin
        crc_nxt       = crc8_update(crc_r, in_ch.data_byte);
        temp_word_nxt = {temp_word_r[WORD_W-1:DATA_W], in_ch.data_byte};
      end
      POS_TEMP_CRC: begin
        temp_ok_nxt = (crc_r == in_ch.data_byte);
        crc_nxt     = CRC_INIT;
      end
      POS_HUM_HI: begin
        crc_nxt    = crc8_update(CRC_INIT, in_ch.data_byte);
        hum_hi_nxt = in_ch.data_byte;
      end
      POS_HUM_LO: begin
        crc_nxt    = crc8_update(crc_r, in_ch.data_byte);
        hum_lo_nxt = in_ch.data_byte;
      end
      default: begin
        crc_nxt = CRC_INIT;
      end
    endcase
    pos_nxt = (pos_eff >= POS_HUM_CRC) ? POS_TEMP_HI : pos_t'(pos_eff + 3'd1);
  end

  // completed frame goes to the queue on the last byte
  assign frm_valid          = in_ch.valid && (pos_eff == POS_HUM_CRC);
  assign frm_data.temp_word = temp_word_r;
  assign frm_data.hum_word  = {hum_hi_r, hum_lo_r};
  assign frm_data.temp_ok   = temp_ok_r;
  assign frm_data.hum_ok    = (crc_r == in_ch.data_byte);

  // position counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_TEMP_HI;
    end else if (accept) begin
      pos_r <= pos_nxt;
    end
  end

  // word capture and crc
  always_ff @(posedge clk) begin
    if (accept) begin
      crc_r       <= crc_nxt;
      temp_word_r <= temp_word_nxt;
      temp_ok_r   <= temp_ok_nxt;
      hum_hi_r    <= hum_hi_nxt;
      hum_lo_r    <= hum_lo_nxt;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_HUM_CRC)
    else $error("frame position out of range");

endmodule

`default_nettype wire

// ----- hw/rtl/hsfd_fifo.sv -----
`default_nettype none

module hsfd_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hsfd_pkg::frame_t  wr_data,
  input  wire logic              wr_valid,
  output logic                   wr_ready,
  output hsfd_pkg::frame_t       rd_data,
  output logic                   rd_valid,
  input  wire logic              rd_ready
);
  import hsfd_pkg::*;

  frame_t                mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r;
  logic                  push, pop;

  assign wr_ready = (count_r != FIFO_CNT_W'(FIFO_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                             : FIFO_PTR_W'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                             : FIFO_PTR_W'(rd_ptr_r + 1'b1);
      end
      count_r <= FIFO_CNT_W'(count_r + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop));
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> count_r == FIFO_CNT_W'($past(count_r) + FIFO_CNT_W'($past(push))
                                     - FIFO_CNT_W'($past(pop))))
    else $error("queue count does not follow push and pop");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == FIFO_CNT_W'(FIFO_DEPTH)) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ----- hw/rtl/hsfd_back.sv -----
`default_nettype none

module hsfd_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire hsfd_pkg::frame_t frm_data,
  input  wire logic             frm_valid,
  output logic                  frm_ready,
  hsfd_out_if.source            out_ch
);
  import hsfd_pkg::*;

  // multiply stage
  logic                     a_valid_r;
  logic [TPROD_W-1:0]       tprod_r;
  logic [HPROD_W-1:0]       hprod_r;
  logic                     a_temp_ok_r, a_hum_ok_r;
  logic                     a_load;

  // output stage
  logic                     out_valid_r;
  logic signed [TEMP_W-1:0] temp_r;
  logic [HUM_W-1:0]         hum_r;
  logic                     temp_ok_r, hum_ok_r;
  logic                     out_load;

  logic signed [TNUM_W-1:0] tnum;
  logic [TNUM_W-1:0]        tmag;
  logic [TEMP_W-1:0]        tdeg;
  logic signed [TEMP_W-1:0] temp_nxt;

  assign out_load  = !out_valid_r || out_ch.ready;
  assign a_load    = !a_valid_r || out_load;
  assign frm_ready = a_load;

  // raw words times scale factors
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_load) begin
      a_valid_r <= frm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load && frm_valid) begin
      tprod_r     <= TPROD_W'(frm_data.temp_word) * TEMP_SCALE;
      hprod_r     <= HPROD_W'(frm_data.hum_word) * HUM_SCALE;
      a_temp_ok_r <= frm_data.temp_ok;
      a_hum_ok_r  <= frm_data.hum_ok;
    end
  end

  // offset and divide by 65536, truncating toward zero
  always_comb begin
    tnum     = $signed({1'b0, tprod_r}) - TEMP_OFFSET;
    tmag     = tnum[TNUM_W-1] ? TNUM_W'(-tnum) : TNUM_W'(tnum);
    tdeg     = tmag[TNUM_W-1:WORD_W];
    temp_nxt = tnum[TNUM_W-1] ? $signed(TEMP_W'(-tdeg)) : $signed(tdeg);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && a_valid_r) begin
      temp_r    <= temp_nxt;
      hum_r     <= hprod_r[HPROD_W-1:WORD_W];
      temp_ok_r <= a_temp_ok_r;
      hum_ok_r  <= a_hum_ok_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.temperature_c = temp_r;
  assign out_ch.humidity_pct  = hum_r;
  assign out_ch.temp_crc_ok   = temp_ok_r;
  assign out_ch.hum_crc_ok    = hum_ok_r;

  a_frame_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (frm_valid && frm_ready) |=> a_valid_r)
    else $error("accepted frame lost before multiply stage");

endmodule

`default_nettype wire

// ----- tb/humidity_sensor_frame_decoder_top_test.sv -----
`timescale 1ns / 100ps

module humidity_sensor_frame_decoder_top_test;
  import hsfd_pkg::*;

  localparam int RANDOM_ITEMS = 550;
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int DRAIN_CYCLES = 20;

  // one decoded sensor reading
  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_c;
    logic        [HUM_W-1:0]  hum_pct;
    logic                     temp_ok;
    logic                     hum_ok;
  } reading_t;

  // one directed byte, with an optional hand-computed reading
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              start;
    logic              typed;
    reading_t          want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  hsfd_in_if  in_ch ();
  hsfd_out_if out_ch ();

  humidity_sensor_frame_decoder_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  reading_t  expected_readings[$];
  stim_row_t dir_rows[$];
  int        errors = 0;
  int        items_sent = 0;
  int        burst_left = 0;
  int        cycles = 0;

  // frame tracker mirror
  pos_t              frame_pos = POS_TEMP_HI;
  logic [DATA_W-1:0] crc_acc = CRC_INIT;
  logic [WORD_W-1:0] raw_temp = '0;
  logic              temp_ok_flag = 1'b0;
  logic [DATA_W-1:0] hum_hi = '0;
  logic [DATA_W-1:0] hum_lo = '0;

  // crc-8 fed one data bit at a time, msb first
  function automatic logic [DATA_W-1:0] crc8_step(logic [DATA_W-1:0] acc,
                                                 logic [DATA_W-1:0] b);
    logic fb;
    for (int i = DATA_W - 1; i >= 0; i--) begin
      fb  = acc[DATA_W-1] ^ b[i];
      acc = {acc[DATA_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
    end
    return acc;
  endfunction

  function automatic logic [DATA_W-1:0] word_crc(logic [WORD_W-1:0] w);
    return crc8_step(crc8_step(CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  // advance the tracker by one byte, produce a reading on the humidity crc byte
  task automatic decode_byte(input logic [DATA_W-1:0] b, input logic s,
                             output bit has_reading, output reading_t r);
    pos_t pos;
    int   num;
    int   hum_val;
    has_reading = 1'b0;
    r = '0;
    pos = (s || frame_pos > POS_HUM_CRC) ? POS_TEMP_HI : frame_pos;
    case (pos)
      POS_TEMP_HI: begin
        crc_acc  = crc8_step(CRC_INIT, b);
        raw_temp = {b, 8'h00};
      end
      POS_TEMP_LO: begin
        crc_acc  = crc8_step(crc_acc, b);
        raw_temp = {raw_temp[15:8], b};
      end
      POS_TEMP_CRC: begin
        temp_ok_flag = (crc_acc == b);
        crc_acc      = CRC_INIT;
      end
      POS_HUM_HI: begin
        crc_acc = crc8_step(CRC_INIT, b);
        hum_hi  = b;
      end
      POS_HUM_LO: begin
        crc_acc = crc8_step(crc_acc, b);
        hum_lo  = b;
      end
      default: begin
        // integer division truncates toward zero
        num       = 175 * int'(raw_temp) - 45 * 65536;
        hum_val   = (100 * int'({hum_hi, hum_lo})) >>> 16;
        r.temp_c  = TEMP_W'(num / 65536);
        r.hum_pct = HUM_W'(hum_val);
        r.temp_ok = temp_ok_flag;
        r.hum_ok  = (crc_acc == b);
        crc_acc   = CRC_INIT;
        has_reading = 1'b1;
      end
    endcase
    frame_pos = (pos >= POS_HUM_CRC) ? POS_TEMP_HI : pos_t'(pos + 1);
  endtask

  // drive one byte in bursts with random gaps, then predict on acceptance
  task automatic send_byte(input logic [DATA_W-1:0] b, input logic s,
                           input logic typed, input reading_t want);
    bit       got;
    reading_t pred;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(40, 120);
      end else begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(1, 10);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.frame_start <= s;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    decode_byte(b, s, got, pred);
    if (got) expected_readings.push_back(typed ? want : pred);
    items_sent++;
  endtask

  function automatic stim_row_t row(logic [DATA_W-1:0] b, logic s, logic t,
                                    int tc, int hp, logic tok, logic hok);
    stim_row_t r;
    r.data         = b;
    r.start        = s;
    r.typed        = t;
    r.want.temp_c  = TEMP_W'(tc);
    r.want.hum_pct = HUM_W'(hp);
    r.want.temp_ok = tok;
    r.want.hum_ok  = hok;
    return r;
  endfunction

  // raw words biased toward the extremes and the zero-degree crossing
  function automatic logic [WORD_W-1:0] pick_raw();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return WORD_W'(16000 + $urandom_range(0, 1800));
      default: return WORD_W'($urandom);
    endcase
  endfunction

  // one random group: mostly good frames, some truncated frames and noise
  task automatic send_random_group();
    logic [WORD_W-1:0] t_raw;
    logic [WORD_W-1:0] h_raw;
    logic [DATA_W-1:0] t_crc;
    logic [DATA_W-1:0] h_crc;
    logic              first_start;
    int                kind;
    int                n;
    kind = $urandom_range(0, 9);
    if (kind <= 7) begin
      t_raw = pick_raw();
      h_raw = pick_raw();
      t_crc = word_crc(t_raw);
      h_crc = word_crc(h_raw);
      if ($urandom_range(0, 7) == 0) t_crc = t_crc ^ DATA_W'($urandom_range(1, 255));
      if ($urandom_range(0, 7) == 0) h_crc = h_crc ^ DATA_W'($urandom_range(1, 255));
      first_start = ($urandom_range(0, 3) != 0);
      n = (kind == 7) ? $urandom_range(1, 5) : 6;
      if (n > 0) send_byte(t_raw[15:8], first_start, 1'b0, '0);
      if (n > 1) send_byte(t_raw[7:0], 1'b0, 1'b0, '0);
      if (n > 2) send_byte(t_crc, 1'b0, 1'b0, '0);
      if (n > 3) send_byte(h_raw[15:8], 1'b0, 1'b0, '0);
      if (n > 4) send_byte(h_raw[7:0], 1'b0, 1'b0, '0);
      if (n > 5) send_byte(h_crc, 1'b0, 1'b0, '0);
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) send_byte(DATA_W'($urandom), logic'($urandom_range(0, 3) == 0), 1'b0, '0);
    end
  endtask

  // receiver ready pattern: a randomly redrawn mode of always, random, sparse or windowed ready
  initial begin
    int mode;
    int tick;
    out_ch.ready = 1'b0;
    mode = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (tick % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= logic'($urandom_range(0, 1));
        2:       out_ch.ready <= ($urandom_range(0, 4) == 0);
        default: out_ch.ready <= ((tick % 32) >= 24);
      endcase
      tick++;
    end
  end

  // compare each accepted reading with the oldest prediction
  always @(posedge clk) begin
    reading_t exp_r;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected reading: temperature_c %0d humidity_pct %0d",
               out_ch.temperature_c, out_ch.humidity_pct);
        errors++;
      end else begin
        exp_r = expected_readings.pop_front();
        if (out_ch.temperature_c !== exp_r.temp_c) begin
          $error("temperature_c: expected %0d, got %0d", exp_r.temp_c, out_ch.temperature_c);
          errors++;
        end
        if (out_ch.humidity_pct !== exp_r.hum_pct) begin
          $error("humidity_pct: expected %0d, got %0d", exp_r.hum_pct, out_ch.humidity_pct);
          errors++;
        end
        if (out_ch.temp_crc_ok !== exp_r.temp_ok) begin
          $error("temp_crc_ok: expected %0b, got %0b", exp_r.temp_ok, out_ch.temp_crc_ok);
          errors++;
        end
        if (out_ch.hum_crc_ok !== exp_r.hum_ok) begin
          $error("hum_crc_ok: expected %0b, got %0b", exp_r.hum_ok, out_ch.hum_crc_ok);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = '0;
    in_ch.frame_start = 1'b0;

    // all-zero words, good crc: coldest reading
    dir_rows.push_back(row(8'h00, 1'b1, 1'b0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(row(8'h00, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(row(8'h81, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(row(8'h00, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(row(8'h00, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(row(8'h81, 1'b0, 1'b1, -45, 0, 1'b1, 1'b1));
    // all-ones words, no start flag: position wraps on its own
    dir_rows.push_back(row(8'hFF, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(row(8'hFF, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(row(8'hAC, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(row(8'hFF, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(row(8'hFF, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(row(8'hAC, 1'b0, 1'b1, 129, 99, 1'b1, 1'b1));
    // good temperature crc, bad humidity crc
    dir_rows.push_back(row(8'hBE, 1'b1, 1'b0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(row(8'hEF, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(row(8'h92, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(row(8'hBE, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(row(8'hEF, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(row(8'h00, 1'b0, 1'b1, 85, 74, 1'b1, 1'b0));
    // frame cut short by a new start, then a slightly negative temperature
    dir_rows.push_back(row(8'h40, 1'b1, 1'b0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(row(8'h00, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(row(8'h40, 1'b1, 1'b0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(row(8'h00, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(row(8'h55, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(row(8'h12, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(row(8'h34, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(row(8'h37, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0));

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed table
    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].data, dir_rows[i].start, dir_rows[i].typed, dir_rows[i].want);
    end

    // random frames
    while (items_sent < RANDOM_ITEMS + dir_rows.size()) send_random_group();

    @(negedge clk);
    in_ch.valid <= 1'b0;

    // drain
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- humidity_sensor_frame_decoder_top.f -----
hw/rtl/hsfd_pkg.sv
hw/rtl/hsfd_if.sv
hw/rtl/hsfd_front.sv
hw/rtl/hsfd_fifo.sv
hw/rtl/hsfd_back.sv
hw/rtl/humidity_sensor_frame_decoder_top.sv
tb/humidity_sensor_frame_decoder_top_test.sv
